[design/ncpa_pkg.sv]
// Shared types, constants and microprogram for the nodal curve point adder.
package ncpa_pkg;

    localparam logic [63:0] MODULUS_RESET = 64'd18446744073709551557;
    localparam int PC_W = 6;

    typedef struct packed {
        logic        mode;
        logic        first_inf;
        logic [63:0] first_x;
        logic [63:0] first_y;
        logic        second_inf;
        logic [63:0] second_x;
        logic [63:0] second_y;
    } in_req_t;

    typedef struct packed {
        logic        sum_inf;
        logic [63:0] sum_x;
        logic [63:0] sum_y;
    } out_rsp_t;

    typedef enum logic [4:0] {
        OP_SETK, OP_LDIN, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_MULQ, OP_DIV,
        OP_JMP, OP_BEQ, OP_BNE, OP_BZ, OP_BDBL, OP_BINF1, OP_BINF2, OP_OUTP, OP_OUTI
    } op_t;

    typedef enum logic [3:0] {
        R_M, R_X1, R_Y1, R_X2, R_Y2, R_L, R_T, R_U,
        R_V, R_R0, R_R1, R_T0, R_T1, R_NR, R_NT, R_K
    } reg_t;

    localparam int NUM_REGS = 16;

    // Constant selectors for OP_SETK.
    localparam logic [1:0] K_ZERO = 2'd0;
    localparam logic [1:0] K_ONE  = 2'd1;
    localparam logic [1:0] K_ONEM = 2'd2;
    localparam logic [1:0] K_MOD  = 2'd3;

    // Field selectors for OP_LDIN.
    localparam logic [1:0] F_X1 = 2'd0;
    localparam logic [1:0] F_Y1 = 2'd1;
    localparam logic [1:0] F_X2 = 2'd2;
    localparam logic [1:0] F_Y2 = 2'd3;

    typedef struct packed {
        op_t              op;
        reg_t             dst;
        reg_t             a;
        reg_t             b;
        logic [1:0]       sel;
        logic [PC_W-1:0]  tgt;
    } instr_t;

    typedef struct packed {
        logic   load;
        logic   exec;
        instr_t ins;
    } cmd_t;

    typedef struct packed {
        logic take;
        logic done;
    } status_t;

    localparam logic [PC_W-1:0] L_LOOP  = 6'd32;
    localparam logic [PC_W-1:0] L_INV   = 6'd29;
    localparam logic [PC_W-1:0] L_DBL   = 6'd20;
    localparam logic [PC_W-1:0] L_DBLY  = 6'd21;
    localparam logic [PC_W-1:0] L_SAMEX = 6'd18;
    localparam logic [PC_W-1:0] L_ENDL  = 6'd41;
    localparam logic [PC_W-1:0] L_INV0  = 6'd44;
    localparam logic [PC_W-1:0] L_TAIL  = 6'd45;
    localparam logic [PC_W-1:0] L_INF   = 6'd53;
    localparam logic [PC_W-1:0] L_INF1  = 6'd54;
    localparam logic [PC_W-1:0] L_P1    = 6'd56;

    function automatic instr_t mk(op_t op, reg_t dst, reg_t a, reg_t b,
                                  logic [1:0] sel, logic [PC_W-1:0] tgt);
        instr_t r;
        r.op  = op;
        r.dst = dst;
        r.a   = a;
        r.b   = b;
        r.sel = sel;
        r.tgt = tgt;
        return r;
    endfunction

    function automatic instr_t ucode(logic [PC_W-1:0] pc);
        instr_t r;
        unique case (pc)
            6'd0:  r = mk(OP_SETK,  R_M,  R_M,  R_M,  K_MOD,  '0);
            6'd1:  r = mk(OP_SETK,  R_K,  R_M,  R_M,  K_ONE,  '0);
            6'd2:  r = mk(OP_LDIN,  R_T,  R_M,  R_M,  F_X1,   '0);
            6'd3:  r = mk(OP_DIV,   R_X1, R_T,  R_M,  K_ZERO, '0);
            6'd4:  r = mk(OP_LDIN,  R_T,  R_M,  R_M,  F_Y1,   '0);
            6'd5:  r = mk(OP_DIV,   R_Y1, R_T,  R_M,  K_ZERO, '0);
            6'd6:  r = mk(OP_LDIN,  R_T,  R_M,  R_M,  F_X2,   '0);
            6'd7:  r = mk(OP_DIV,   R_X2, R_T,  R_M,  K_ZERO, '0);
            6'd8:  r = mk(OP_LDIN,  R_T,  R_M,  R_M,  F_Y2,   '0);
            6'd9:  r = mk(OP_DIV,   R_Y2, R_T,  R_M,  K_ZERO, '0);
            6'd10: r = mk(OP_BDBL,  R_M,  R_M,  R_M,  K_ZERO, L_DBL);
            6'd11: r = mk(OP_BINF1, R_M,  R_M,  R_M,  K_ZERO, L_INF1);
            6'd12: r = mk(OP_BINF2, R_M,  R_M,  R_M,  K_ZERO, L_P1);
            6'd13: r = mk(OP_BEQ,   R_M,  R_X1, R_X2, K_ZERO, L_SAMEX);
            6'd14: r = mk(OP_SUB,   R_R1, R_X2, R_X1, K_ZERO, '0);
            6'd15: r = mk(OP_SUB,   R_U,  R_Y2, R_Y1, K_ZERO, '0);
            6'd16: r = mk(OP_ADD,   R_V,  R_X1, R_X2, K_ZERO, '0);
            6'd17: r = mk(OP_JMP,   R_M,  R_M,  R_M,  K_ZERO, L_INV);
            6'd18: r = mk(OP_BNE,   R_M,  R_Y1, R_Y2, K_ZERO, L_INF);
            6'd19: r = mk(OP_JMP,   R_M,  R_M,  R_M,  K_ZERO, L_DBLY);
            6'd20: r = mk(OP_BINF1, R_M,  R_M,  R_M,  K_ZERO, L_INF);
            6'd21: r = mk(OP_BZ,    R_M,  R_Y1, R_M,  K_ZERO, L_INF);
            6'd22: r = mk(OP_ADD,   R_V,  R_X1, R_X1, K_ZERO, '0);
            6'd23: r = mk(OP_ADD,   R_U,  R_V,  R_X1, K_ZERO, '0);
            6'd24: r = mk(OP_SETK,  R_T,  R_M,  R_M,  K_ONEM, '0);
            6'd25: r = mk(OP_ADD,   R_T,  R_T,  R_T,  K_ZERO, '0);
            6'd26: r = mk(OP_ADD,   R_U,  R_U,  R_T,  K_ZERO, '0);
            6'd27: r = mk(OP_MUL,   R_U,  R_U,  R_X1, K_ZERO, '0);
            6'd28: r = mk(OP_ADD,   R_R1, R_Y1, R_Y1, K_ZERO, '0);
            6'd29: r = mk(OP_MOV,   R_R0, R_M,  R_M,  K_ZERO, '0);
            6'd30: r = mk(OP_SETK,  R_T0, R_M,  R_M,  K_ZERO, '0);
            6'd31: r = mk(OP_SETK,  R_T1, R_M,  R_M,  K_ONEM, '0);
            6'd32: r = mk(OP_BZ,    R_M,  R_R1, R_M,  K_ZERO, L_ENDL);
            6'd33: r = mk(OP_DIV,   R_NR, R_R0, R_R1, K_ZERO, '0);
            6'd34: r = mk(OP_MULQ,  R_T,  R_T1, R_M,  K_ZERO, '0);
            6'd35: r = mk(OP_SUB,   R_NT, R_T0, R_T,  K_ZERO, '0);
            6'd36: r = mk(OP_MOV,   R_R0, R_R1, R_M,  K_ZERO, '0);
            6'd37: r = mk(OP_MOV,   R_R1, R_NR, R_M,  K_ZERO, '0);
            6'd38: r = mk(OP_MOV,   R_T0, R_T1, R_M,  K_ZERO, '0);
            6'd39: r = mk(OP_MOV,   R_T1, R_NT, R_M,  K_ZERO, '0);
            6'd40: r = mk(OP_JMP,   R_M,  R_M,  R_M,  K_ZERO, L_LOOP);
            6'd41: r = mk(OP_BNE,   R_M,  R_R0, R_K,  K_ZERO, L_INV0);
            6'd42: r = mk(OP_MUL,   R_L,  R_U,  R_T0, K_ZERO, '0);
            6'd43: r = mk(OP_JMP,   R_M,  R_M,  R_M,  K_ZERO, L_TAIL);
            6'd44: r = mk(OP_SETK,  R_L,  R_M,  R_M,  K_ZERO, '0);
            6'd45: r = mk(OP_MUL,   R_T,  R_L,  R_L,  K_ZERO, '0);
            6'd46: r = mk(OP_SUB,   R_T,  R_T,  R_V,  K_ZERO, '0);
            6'd47: r = mk(OP_SETK,  R_U,  R_M,  R_M,  K_ONEM, '0);
            6'd48: r = mk(OP_SUB,   R_T,  R_T,  R_U,  K_ZERO, '0);
            6'd49: r = mk(OP_SUB,   R_U,  R_X1, R_T,  K_ZERO, '0);
            6'd50: r = mk(OP_MUL,   R_U,  R_U,  R_L,  K_ZERO, '0);
            6'd51: r = mk(OP_SUB,   R_U,  R_U,  R_Y1, K_ZERO, '0);
            6'd52: r = mk(OP_OUTP,  R_M,  R_T,  R_U,  K_ZERO, '0);
            6'd53: r = mk(OP_OUTI,  R_M,  R_M,  R_M,  K_ZERO, '0);
            6'd54: r = mk(OP_BINF2, R_M,  R_M,  R_M,  K_ZERO, L_INF);
            6'd55: r = mk(OP_OUTP,  R_M,  R_X2, R_Y2, K_ZERO, '0);
            6'd56: r = mk(OP_OUTP,  R_M,  R_X1, R_Y1, K_ZERO, '0);
            default: r = mk(OP_OUTI, R_M, R_M,  R_M,  K_ZERO, '0);
        endcase
        return r;
    endfunction

endpackage

[design/ncpa_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
module ncpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

[design/ncpa_datapath.sv]
// Datapath: register RAM, modular adder, serial multiplier and serial divider.
module ncpa_datapath #(
    parameter int W = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [63:0]       modulus,
    input  ncpa_pkg::in_req_t in_req,
    input  ncpa_pkg::cmd_t    cmd,
    output ncpa_pkg::status_t status,
    output ncpa_pkg::out_rsp_t out_rsp
);

    localparam int CW = $clog2(W);

    ncpa_pkg::in_req_t in_reg;
    ncpa_pkg::out_rsp_t rsp_reg;
    ncpa_pkg::instr_t ins;

    logic [W-1:0] mw;
    logic [W-1:0] fm;
    logic [W-1:0] ra;
    logic [W-1:0] rb;
    logic [W-1:0] add_r;
    logic [W-1:0] sub_r;
    logic [W-1:0] kval;
    logic [W-1:0] fld;
    logic [W-1:0] alu;
    logic [W-1:0] qm;
    logic         wr_en;
    logic [W-1:0] wr_data;

    logic          busy_reg;
    logic          is_div_reg;
    logic [CW-1:0] cnt_reg;
    logic          last;
    logic [W-1:0]  ma_reg;
    logic [W-1:0]  mb_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  m2;
    logic [W-1:0]  acc_next;
    logic [W-1:0]  dn_reg;
    logic [W-1:0]  dd_reg;
    logic [W-1:0]  drem_reg;
    logic [W-1:0]  dq_reg;
    logic [W-1:0]  q_reg;
    logic [W:0]    dtry;
    logic          dge;
    logic [W-1:0]  drem_next;
    logic [W-1:0]  dq_next;
    logic          start;

    function automatic logic [W-1:0] madd(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    assign ins = cmd.ins;
    assign mw  = modulus[W-1:0];
    assign fm  = (mw[W-1:1] == '0) ? W'(1) : mw;

    ncpa_ram #(
        .WIDTH(W),
        .DEPTH(ncpa_pkg::NUM_REGS)
    ) u_regs (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (ins.dst),
        .wdata   (wr_data),
        .raddr_a (ins.a),
        .raddr_b (ins.b),
        .rdata_a (ra),
        .rdata_b (rb)
    );

    assign add_r = madd(ra, rb, fm);
    assign sub_r = (ra >= rb) ? (ra - rb) : (ra - rb + fm);
    assign qm    = (q_reg == fm) ? '0 : q_reg;

    always_comb
    begin
        case (ins.sel)
            ncpa_pkg::K_ZERO: kval = '0;
            ncpa_pkg::K_ONE:  kval = W'(1);
            ncpa_pkg::K_ONEM: kval = (fm == W'(1)) ? '0 : W'(1);
            default:          kval = fm;
        endcase
        case (ins.sel)
            ncpa_pkg::F_X1: fld = in_reg.first_x[W-1:0];
            ncpa_pkg::F_Y1: fld = in_reg.first_y[W-1:0];
            ncpa_pkg::F_X2: fld = in_reg.second_x[W-1:0];
            default:        fld = in_reg.second_y[W-1:0];
        endcase
    end

    // Serial units: one multiplier bit or one quotient bit per cycle.
    assign last      = busy_reg && (cnt_reg == '0);
    assign m2        = madd(acc_reg, acc_reg, fm);
    assign acc_next  = mb_reg[W-1] ? madd(m2, ma_reg, fm) : m2;
    assign dtry      = {drem_reg, dn_reg[W-1]};
    assign dge       = dtry >= {1'b0, dd_reg};
    assign drem_next = dge ? W'(dtry - {1'b0, dd_reg}) : dtry[W-1:0];
    assign dq_next   = {dq_reg[W-2:0], dge};

    always_comb
    begin
        alu   = ra;
        wr_en = 1'b0;
        start = 1'b0;
        case (ins.op) inside
            ncpa_pkg::OP_SETK: alu = kval;
            ncpa_pkg::OP_LDIN: alu = fld;
            ncpa_pkg::OP_ADD:  alu = add_r;
            ncpa_pkg::OP_SUB:  alu = sub_r;
            default:           alu = ra;
        endcase
        case (ins.op) inside
            ncpa_pkg::OP_SETK, ncpa_pkg::OP_LDIN, ncpa_pkg::OP_MOV,
            ncpa_pkg::OP_ADD, ncpa_pkg::OP_SUB:
                wr_en = cmd.exec;
            ncpa_pkg::OP_MUL, ncpa_pkg::OP_MULQ, ncpa_pkg::OP_DIV:
                start = cmd.exec;
            default:
                wr_en = 1'b0;
        endcase
        wr_data = alu;
        if (last)
        begin
            wr_en   = 1'b1;
            wr_data = is_div_reg ? drem_next : acc_next;
        end
    end

    always_comb
    begin
        case (ins.op)
            ncpa_pkg::OP_JMP:   status.take = 1'b1;
            ncpa_pkg::OP_BEQ:   status.take = (ra == rb);
            ncpa_pkg::OP_BNE:   status.take = (ra != rb);
            ncpa_pkg::OP_BZ:    status.take = (ra == '0);
            ncpa_pkg::OP_BDBL:  status.take = in_reg.mode;
            ncpa_pkg::OP_BINF1: status.take = in_reg.first_inf;
            ncpa_pkg::OP_BINF2: status.take = in_reg.second_inf;
            default:            status.take = 1'b0;
        endcase
        status.done = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            is_div_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg   <= 1'b1;
            is_div_reg <= (ins.op == ncpa_pkg::OP_DIV);
            cnt_reg    <= CW'(W - 1);
        end
        else if (busy_reg)
        begin
            busy_reg <= !last;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_req;
        end
        if (start)
        begin
            acc_reg  <= '0;
            drem_reg <= '0;
            dq_reg   <= '0;
            dn_reg   <= ra;
            dd_reg   <= rb;
            if (ins.op == ncpa_pkg::OP_MULQ)
            begin
                ma_reg <= qm;
                mb_reg <= ra;
            end
            else
            begin
                ma_reg <= ra;
                mb_reg <= rb;
            end
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            mb_reg   <= mb_reg << 1;
            drem_reg <= drem_next;
            dq_reg   <= dq_next;
            dn_reg   <= dn_reg << 1;
            if (last && is_div_reg)
            begin
                q_reg <= dq_next;
            end
        end
        if (cmd.exec && ins.op == ncpa_pkg::OP_OUTP)
        begin
            rsp_reg.sum_inf <= 1'b0;
            rsp_reg.sum_x   <= 64'(ra);
            rsp_reg.sum_y   <= 64'(rb);
        end
        else if (cmd.exec && ins.op == ncpa_pkg::OP_OUTI)
        begin
            rsp_reg.sum_inf <= 1'b1;
            rsp_reg.sum_x   <= '0;
            rsp_reg.sum_y   <= '0;
        end
    end

    assign out_rsp = rsp_reg;

endmodule

[design/ncpa_ctrl.sv]
// Controller: microprogram sequencer and request/result handshakes.
module ncpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ncpa_pkg::status_t status,
    output ncpa_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_WAIT} state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [ncpa_pkg::PC_W-1:0]  pc_reg;
    logic [ncpa_pkg::PC_W-1:0]  pc_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_free;
    logic                       is_out;
    ncpa_pkg::instr_t           ins;

    assign ins      = ncpa_pkg::ucode(pc_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign is_out   = (ins.op == ncpa_pkg::OP_OUTP) || (ins.op == ncpa_pkg::OP_OUTI);

    assign cmd.ins  = ins;
    assign cmd.load = (state_reg == S_IDLE) && in_valid;
    assign cmd.exec = (state_reg == S_EXEC) && (!is_out || out_free);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pc_next    = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                unique case (ins.op) inside
                    ncpa_pkg::OP_MUL, ncpa_pkg::OP_MULQ, ncpa_pkg::OP_DIV:
                        state_next = S_WAIT;
                    ncpa_pkg::OP_JMP, ncpa_pkg::OP_BEQ, ncpa_pkg::OP_BNE, ncpa_pkg::OP_BZ,
                    ncpa_pkg::OP_BDBL, ncpa_pkg::OP_BINF1, ncpa_pkg::OP_BINF2:
                    begin
                        pc_next    = status.take ? ins.tgt : pc_reg + 1'b1;
                        state_next = S_READ;
                    end
                    ncpa_pkg::OP_OUTP, ncpa_pkg::OP_OUTI:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_IDLE;
                        end
                    end
                    default:
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_READ;
                    end
                endcase
            end
            S_WAIT:
            begin
                if (status.done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_READ))
        else $error("accepted request did not start the sequencer");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (state_reg == S_WAIT))
        else $error("serial unit finished outside the wait state");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_EXEC))
        else $error("result appeared without an output instruction");

endmodule

[design/nodal_curve_point_add.sv]
// Top level of the nodal curve point adder: configuration register, controller and datapath.
// Adds two affine points, or doubles the first, on y^2 = x^3 + x^2 modulo the configured
// modulus, one request at a time. Input reduction runs four serial divisions, and the slope
// inversion is an extended Euclid loop in which every step runs one serial division and one
// serial modular multiplication plus its microcode instructions, for up to about 1.5*W steps.
// A result may wait for the consumer while the block is idle; the next request is taken once
// the result is loaded.
module nodal_curve_point_add #(
    parameter int COORD_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ncpa_pkg::in_req_t  in_req,
    output logic               out_valid,
    input  logic               out_stall,
    output ncpa_pkg::out_rsp_t out_rsp,
    input  logic               cfg_we,
    input  logic [63:0]        cfg_wdata
);

    logic [63:0]       modulus_reg;
    ncpa_pkg::cmd_t    cmd;
    ncpa_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= ncpa_pkg::MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    ncpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ncpa_datapath #(
        .W(COORD_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .in_req  (in_req),
        .cmd     (cmd),
        .status  (status),
        .out_rsp (out_rsp)
    );

endmodule
